### src/mtsr_pkg.sv
// Shared constants and types for the mouse-to-stick radial clamp.
`timescale 1ns / 1ps
package mtsr_pkg;
  localparam int MAX_MAGNITUDE = 16;
  localparam int STICK_MID = 128;
  localparam int STICK_MAX = 255;
  localparam int SCALE = 128 / MAX_MAGNITUDE;
  localparam logic [15:0] LIM2 = 16'(MAX_MAGNITUDE * MAX_MAGNITUDE);
  localparam int SUM_W = 16;
  localparam int ROOT_W = 24;
  localparam int REM_W = 49;
  localparam int NUM_W = 31;
  localparam int QUO_W = 8;
  localparam int DREM_W = NUM_W + 1;
  localparam int SQ_STAGES = ROOT_W;
  localparam int DIV_STAGES = QUO_W;
  localparam int SB_LAST = SQ_STAGES + DIV_STAGES;

  typedef struct packed {
    logic [13:0]      pad;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic             clamp;
    logic [NUM_W-1:0] numx;
    logic [NUM_W-1:0] numy;
  } sb_t;
endpackage

### src/mtsr_sqrt.sv
// Pipelined square root: one root bit per stage.
`timescale 1ns / 1ps
module mtsr_sqrt import mtsr_pkg::*; (
  input  logic              clk,
  input  logic [SUM_W-1:0]  sum,
  output logic [ROOT_W-1:0] root
);
  logic [REM_W-1:0]  rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0] root_q [0:ROOT_W];

  assign rem_q[0]  = REM_W'({sum, 32'b0});
  assign root_q[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [REM_W-1:0] delta;
    assign delta = (REM_W'(root_q[k]) << (B + 1)) + (REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rem_q[k] >= delta) begin
        rem_q[k+1]  <= rem_q[k] - delta;
        root_q[k+1] <= root_q[k] | (ROOT_W'(1) << B);
      end else begin
        rem_q[k+1]  <= rem_q[k];
        root_q[k+1] <= root_q[k];
      end
    end
  end

  assign root = root_q[ROOT_W];
endmodule

### src/mtsr_div.sv
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps
module mtsr_div import mtsr_pkg::*; (
  input  logic              clk,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [QUO_W-1:0]  quo
);
  logic [DREM_W-1:0] rem_q [0:QUO_W];
  logic [ROOT_W-1:0] den_q [0:QUO_W];
  logic [QUO_W-1:0]  quo_q [0:QUO_W];

  assign rem_q[0] = DREM_W'(num);
  assign den_q[0] = den;
  assign quo_q[0] = '0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [DREM_W-1:0] trial;
    assign trial = DREM_W'(den_q[k]) << B;
    always_ff @(posedge clk) begin
      den_q[k+1] <= den_q[k];
      if (rem_q[k] >= trial) begin
        rem_q[k+1] <= rem_q[k] - trial;
        quo_q[k+1] <= quo_q[k] | (QUO_W'(1) << B);
      end else begin
        rem_q[k+1] <= rem_q[k];
        quo_q[k+1] <= quo_q[k];
      end
    end
  end

  assign quo = quo_q[QUO_W];
endmodule

### src/mouse_to_stick_radial_clamp_unit.sv
// Pipeline from start to strobe: 1 input, 24 root, 8 divide, 1 output stage.
// Throughput: one item per cycle; busy is never raised, each root bit and quotient bit
// has its own pipeline stage.
// Reset clears the valid bits and strobe only; payload registers are not reset.
// The receiver cannot stall, so no item is ever held back in the pipeline.
`timescale 1ns / 1ps
module mouse_to_stick_radial_clamp_unit import mtsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        mouse_buttons,
  input  logic signed [7:0] delta_x,
  input  logic signed [7:0] delta_y,
  output logic              strobe,
  output logic [13:0]       pad_buttons,
  output logic [7:0]        stick_x,
  output logic [7:0]        stick_y
);
  logic [SB_LAST:0] valid;
  sb_t              sb [0:SB_LAST];
  logic [SUM_W-1:0] sum;
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0] qx, qy;
  logic [13:0]      pad_next;
  logic [7:0]       ux, uy;
  logic signed [8:0] ax, ay;
  logic [7:0]       sx_next, sy_next;

  assign busy = 1'b0;

  always_comb begin
    pad_next = '0;
    pad_next[2] = mouse_buttons[0];
    pad_next[4] = mouse_buttons[1];
    pad_next[9] = mouse_buttons[2];
    pad_next[1] = mouse_buttons[3];
    pad_next[5] = mouse_buttons[4];
    ux = delta_x[7] ? 8'(-delta_x) : 8'(delta_x);
    uy = delta_y[7] ? 8'(-delta_y) : 8'(delta_y);
  end

  // input stage: squared length, clamp flag, button remap, scaled numerators
  always_ff @(posedge clk) begin
    sum <= SUM_W'(ux * ux) + SUM_W'(uy * uy);
    sb[0].pad   <= pad_next;
    sb[0].x     <= delta_x;
    sb[0].y     <= delta_y;
    sb[0].clamp <= (SUM_W'(ux * ux) + SUM_W'(uy * uy)) > LIM2;
    sb[0].numx  <= NUM_W'(ux * MAX_MAGNITUDE) << 16;
    sb[0].numy  <= NUM_W'(uy * MAX_MAGNITUDE) << 16;
  end

  for (genvar k = 0; k < SB_LAST; k++) begin : g_sb
    always_ff @(posedge clk) begin
      sb[k+1] <= sb[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      strobe <= 1'b0;
    end else begin
      valid  <= {valid[SB_LAST-1:0], start};
      strobe <= valid[SB_LAST];
    end
  end

  mtsr_sqrt u_sqrt (.clk(clk), .sum(sum), .root(root));
  mtsr_div  u_divx (.clk(clk), .num(sb[SQ_STAGES].numx), .den(root), .quo(qx));
  mtsr_div  u_divy (.clk(clk), .num(sb[SQ_STAGES].numy), .den(root), .quo(qy));

  function automatic logic [7:0] to_stick(input logic signed [8:0] a);
    logic signed [17:0] s;
    s = 18'(a) * 18'(SCALE) + 18'(STICK_MID);
    if (s > 18'(STICK_MAX)) return 8'(STICK_MAX);
    else if (s < 0) return 8'd0;
    else return s[7:0];
  endfunction

  always_comb begin
    if (sb[SB_LAST].clamp) begin
      ax = sb[SB_LAST].x[7] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      ay = sb[SB_LAST].y[7] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end else begin
      ax = 9'(sb[SB_LAST].x);
      ay = 9'(sb[SB_LAST].y);
    end
    sx_next = to_stick(ax);
    sy_next = to_stick(ay);
  end

  always_ff @(posedge clk) begin
    pad_buttons <= sb[SB_LAST].pad;
    stick_x     <= sx_next;
    stick_y     <= sy_next;
  end
endmodule

### bench/tb_top.sv
// Self-checking bench for the mouse-to-stick radial clamp unit.
`timescale 1ns / 1ps
module tb_top;
  import mtsr_pkg::*;

  typedef struct packed {
    logic [7:0]        buttons;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } report_t;

  typedef struct packed {
    logic [13:0] pad;
    logic [7:0]  sx;
    logic [7:0]  sy;
  } pad_state_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [7:0]        mouse_buttons;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic              strobe;
  logic [13:0]       pad_buttons;
  logic [7:0]        stick_x;
  logic [7:0]        stick_y;

  report_t    pending_reports[$];
  pad_state_t expected_pads[$];
  int         mismatches = 0;
  int         accepted = 0;
  int         idle_pct = 0;

  mouse_to_stick_radial_clamp_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mouse_buttons(mouse_buttons), .delta_x(delta_x), .delta_y(delta_y),
    .strobe(strobe), .pad_buttons(pad_buttons), .stick_x(stick_x), .stick_y(stick_y)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // 16.16 bit-serial square root with the overflow-safe tail
  function automatic logic [31:0] sqrt_fixed(input logic [31:0] v);
    logic [31:0] t;
    logic [31:0] q;
    logic [31:0] bitv;
    logic [31:0] rem;
    q = 0;
    bitv = 32'h4000_0000;
    rem = v;
    if (rem < 32'h4000_0200) begin
      while (bitv != 32'h40) begin
        t = q + bitv;
        if (rem >= t) begin
          rem = rem - t;
          q = t + bitv;
        end
        rem = rem << 1;
        bitv = bitv >> 1;
      end
      return q >> 8;
    end
    while (bitv > 32'h40) begin
      t = q + bitv;
      if (rem >= t) begin
        rem = rem - t;
        q = t + bitv;
      end
      if (rem[31]) begin
        q = q >> 1;
        bitv = bitv >> 1;
        rem = rem >> 1;
        while (bitv > 32'h20) begin
          t = q + bitv;
          if (rem >= t) begin
            rem = rem - t;
            q = t + bitv;
          end
          rem = rem << 1;
          bitv = bitv >> 1;
        end
        return q >> 7;
      end
      rem = rem << 1;
      bitv = bitv >> 1;
    end
    return q >> 8;
  endfunction

  function automatic logic [7:0] axis_to_stick(input longint axis);
    longint s;
    s = axis * longint'(SCALE) + longint'(STICK_MID);
    if (s > STICK_MAX) return 8'(STICK_MAX);
    if (s < 0) return 8'd0;
    return 8'(s);
  endfunction

  function automatic pad_state_t map_report(input report_t r);
    pad_state_t p;
    longint x;
    longint y;
    longint ax;
    longint ay;
    logic [31:0] len2;
    logic [31:0] lim2;
    logic [31:0] len;
    x = r.dx;
    y = r.dy;
    ax = x;
    ay = y;
    p.pad = '0;
    p.pad[2] = r.buttons[0];
    p.pad[4] = r.buttons[1];
    p.pad[9] = r.buttons[2];
    p.pad[1] = r.buttons[3];
    p.pad[5] = r.buttons[4];
    len2 = 32'(x * x + y * y) << 16;
    lim2 = 32'(MAX_MAGNITUDE * MAX_MAGNITUDE) << 16;
    if (len2 > lim2) begin
      len = sqrt_fixed(len2);
      if (len == 0) begin
        ax = 0;
        ay = 0;
      end else begin
        ax = (longint'(MAX_MAGNITUDE) * x * 65536) / longint'(len);
        ay = (longint'(MAX_MAGNITUDE) * y * 65536) / longint'(len);
      end
    end
    p.sx = axis_to_stick(ax);
    p.sy = axis_to_stick(ay);
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Driver: hold an item while busy, otherwise advance or idle
  always @(posedge clk) begin
    report_t r;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        r.buttons = mouse_buttons;
        r.dx = delta_x;
        r.dy = delta_y;
        expected_pads.push_back(map_report(r));
        accepted++;
      end
      if (!(start && busy)) begin
        if (pending_reports.size() > 0 && $urandom_range(99) >= idle_pct) begin
          r = pending_reports.pop_front();
          start <= 1'b1;
          mouse_buttons <= r.buttons;
          delta_x <= r.dx;
          delta_y <= r.dy;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    pad_state_t e;
    if (!rst && strobe) begin
      if (expected_pads.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        e = expected_pads.pop_front();
        if (pad_buttons !== e.pad) report_mismatch("pad_buttons", pad_buttons, e.pad);
        if (stick_x !== e.sx) report_mismatch("stick_x", stick_x, e.sx);
        if (stick_y !== e.sy) report_mismatch("stick_y", stick_y, e.sy);
      end
    end
  end

  task automatic add_report(input int b, input int x, input int y);
    report_t r;
    r.buttons = 8'(b);
    r.dx = 8'(x);
    r.dy = 8'(y);
    pending_reports.push_back(r);
  endtask

  initial begin
    int i;
    int x;
    int y;
    rst = 1'b1;
    start = 1'b0;
    mouse_buttons = '0;
    delta_x = '0;
    delta_y = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // corners, axes, the clamp boundary and every button
    add_report(0, 0, 0);
    add_report(255, -128, -128);
    add_report(1, 127, 127);
    add_report(2, -128, 127);
    add_report(4, 127, -128);
    add_report(8, 0, -128);
    add_report(16, -128, 0);
    add_report(32, 16, 0);
    add_report(64, 17, 0);
    add_report(128, 0, -16);
    add_report(31, 11, 11);
    add_report(224, 12, 12);
    add_report(0, -12, 12);
    add_report(3, 1, -1);
    add_report(5, 15, -15);
    add_report(255, 127, 0);
    add_report(0, -1, -128);

    for (i = 0; i < 1250; i++) begin
      if ($urandom_range(1)) begin
        x = $urandom_range(40) - 20;
        y = $urandom_range(40) - 20;
      end else begin
        x = $urandom_range(255) - 128;
        y = $urandom_range(255) - 128;
      end
      add_report($urandom_range(255), x, y);
    end

    // idle phases by progress through the stimulus
    while (pending_reports.size() > 0) begin
      @(posedge clk);
      case ((accepted * 5) / 1267)
        0: idle_pct = 0;
        1: idle_pct = 47;
        2: idle_pct = 0;
        3: idle_pct = 28;
        default: idle_pct = 47;
      endcase
    end
    while (start || expected_pads.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

### mouse_to_stick_radial_clamp_unit.f
src/mtsr_pkg.sv
src/mtsr_sqrt.sv
src/mtsr_div.sv
src/mouse_to_stick_radial_clamp_unit.sv
bench/tb_top.sv
